/* design/ple_pkg.sv */
`timescale 1ns / 1ps
// ple_pkg: shared constants, codes and the command word broadcast to the cell chain
// depends on nothing; used by every module of the list engine
package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int LEN_W    = 6;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // operation codes carried by opcode
  localparam logic [2:0] OP_APPEND    = 3'd0;
  localparam logic [2:0] OP_PREPEND   = 3'd1;
  localparam logic [2:0] OP_INSERT    = 3'd2;
  localparam logic [2:0] OP_REM_LAST  = 3'd3;
  localparam logic [2:0] OP_REM_FIRST = 3'd4;
  localparam logic [2:0] OP_REM_POS   = 3'd5;
  localparam logic [2:0] OP_READ_ALL  = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // what every cell does in one cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [CNT_W-1:0]          slot;
    logic [CNT_W-1:0]          count;
    logic signed [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

/* design/ple_cell.sv */
`timescale 1ns / 1ps
// ple_cell: one storage cell of the list chain, shifts toward either neighbor
// depends on ple_pkg
module ple_cell
  import ple_pkg::*;
(
  input  logic                       clk,
  input  logic [IDX_W-1:0]           idx,
  input  cell_cmd_t                  cmd,
  input  logic signed [DATA_W-1:0]   left,
  input  logic signed [DATA_W-1:0]   right,
  output logic signed [DATA_W-1:0]   data
);

  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] pos_plus;

  assign pos      = CNT_W'(idx);
  assign pos_plus = CNT_W'({1'b0, idx} + 1'b1);

  // element update for the broadcast command
  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        if (pos > cmd.slot) begin
          data <= left;
        end else if (pos == cmd.slot) begin
          data <= cmd.value;
        end
      end
      CELL_REMOVE: begin
        if (pos >= cmd.slot) begin
          data <= right;
        end
      end
      CELL_ROTATE: begin
        if (pos_plus < cmd.count) begin
          data <= right;
        end else if (pos_plus == cmd.count) begin
          data <= cmd.value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/positional_list_engine.sv */
`timescale 1ns / 1ps
// positional_list_engine: top level, command sequencer, output register and cell chain
// depends on ple_pkg and ple_cell
//
// An ordered list of up to CAPACITY signed 32-bit values held in a row of cells, one
// element per cell, front of the list in cell 0. Each input word is captured while idle
// and applied to the whole chain once the output register is free, so an update (append,
// prepend, insert, or any remove) yields one result word. A read-all yields one word per
// element: while the output register is free, the first count cells rotate by one place
// per step, cell 0 feeds the output, and after count steps the list is back in order.
// A new input word is taken only once the previous one has left its last result in the
// output register, which lets that result wait while the next input word is captured.
// Storage needs no clearing after reset; only cells below the count are ever read.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                opcode,
  input  logic [POS_W-1:0]          position,
  input  logic signed [DATA_W-1:0]  value_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DATA_W-1:0]  value_out,
  output logic [1:0]                status,
  output logic [LEN_W-1:0]          length,
  output logic                      last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [CNT_W-1:0]          rd_idx;
  logic [2:0]                op_reg;
  logic [POS_W-1:0]          pos_reg;
  logic signed [DATA_W-1:0]  val_reg;
  logic [1:0]                status_next;
  logic                      out_free;
  logic                      rd_last;
  logic [CMP_W-1:0]          pos_ext;
  logic [CMP_W-1:0]          cnt_ext;
  logic [CMP_W-1:0]          ins_req;
  logic [CMP_W-1:0]          rem_req;
  logic [CNT_W-1:0]          ins_slot;
  logic [CNT_W-1:0]          rem_slot;
  cell_cmd_t                 cmd;
  logic signed [DATA_W-1:0]  cell_data [CAPACITY];

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign rd_last  = (CNT_W'({1'b0, rd_idx} + 1'b1) == count);

  // target slot for inserts and removes, clamped to the current list
  assign pos_ext = CMP_W'(pos_reg);
  assign cnt_ext = CMP_W'(count);

  always_comb begin
    case (op_reg)
      OP_PREPEND: ins_req = '0;
      OP_INSERT:  ins_req = (pos_reg == '0) ? cnt_ext : pos_ext - 1'b1;
      default:    ins_req = cnt_ext;
    endcase
    case (op_reg)
      OP_REM_FIRST: rem_req = '0;
      OP_REM_POS:   rem_req = (pos_reg == '0) ? cnt_ext : pos_ext - 1'b1;
      default:      rem_req = cnt_ext - 1'b1;
    endcase
  end

  assign ins_slot = (ins_req > cnt_ext) ? count : CNT_W'(ins_req);
  assign rem_slot = (rem_req >= cnt_ext) ? CNT_W'(cnt_ext - 1'b1) : CNT_W'(rem_req);

  // sequencer and chain command
  always_comb begin
    state_next  = state;
    count_next  = count;
    status_next = ST_OK;
    cmd.op      = CELL_HOLD;
    cmd.slot    = '0;
    cmd.count   = count;
    cmd.value   = val_reg;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_reg) inside
          OP_APPEND, OP_PREPEND, OP_INSERT: begin
            if (cnt_ext >= CMP_W'(CAPACITY)) begin
              status_next = ST_FULL;
            end else begin
              cmd.op     = CELL_INSERT;
              cmd.slot   = ins_slot;
              count_next = count + 1'b1;
            end
          end
          OP_REM_LAST, OP_REM_FIRST, OP_REM_POS: begin
            if (count == '0) begin
              status_next = ST_EMPTY;
            end else begin
              cmd.op     = CELL_REMOVE;
              cmd.slot   = rem_slot;
              count_next = count - 1'b1;
            end
          end
          OP_READ_ALL: begin
            if (count == '0) begin
              status_next = ST_EMPTY;
            end
          end
          default: begin
          end
        endcase
        if (!out_free) begin
          cmd.op     = CELL_HOLD;
          count_next = count;
        end else if (op_reg == OP_READ_ALL && count != '0) begin
          state_next = S_READ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.op    = CELL_ROTATE;
          cmd.value = cell_data[0];
          if (rd_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (out_free) begin
        if (state == S_READ) begin
          out_valid <= 1'b1;
        end else if (state == S_EXEC && !(op_reg == OP_READ_ALL && count != '0)) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  // captured input word, read index and output word
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_reg  <= opcode;
      pos_reg <= position;
      val_reg <= value_in;
    end
    if (state == S_EXEC) begin
      rd_idx <= '0;
    end else if (state == S_READ && out_free) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (out_free) begin
      if (state == S_EXEC) begin
        value_out <= '0;
        status    <= status_next;
        length    <= LEN_W'(count_next);
        last      <= 1'b1;
      end else if (state == S_READ) begin
        value_out <= cell_data[0];
        status    <= ST_OK;
        length    <= LEN_W'(count);
        last      <= rd_last;
      end
    end
  end

  // chain of list cells, each linked to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;
    if (i == 0) begin : g_head
      assign left_in = '0;
    end else begin : g_body
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_link
      assign right_in = cell_data[i+1];
    end
    ple_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .cmd   (cmd),
      .left  (left_in),
      .right (right_in),
      .data  (cell_data[i])
    );
  end

endmodule

/* design/ple_checker.sv */
`timescale 1ns / 1ps
// ple_checker: port-level checks of the list engine, bound to the top level
// depends on ple_pkg and positional_list_engine
module ple_checker
  import ple_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [DATA_W-1:0]  value_out,
  input logic [1:0]                status,
  input logic [LEN_W-1:0]          length,
  input logic                      last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(status)
      && $stable(length) && $stable(last))
    else $error("stalled result word changed");

  // an empty report is a single zero word with no elements
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> length == '0 && last && value_out == '0)
    else $error("empty status with elements or data");

  // a dropped insert only happens on a full list
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> length == LEN_W'(CAPACITY) && last)
    else $error("full status below capacity");

  // only read-out produces words that are not final, and those are ok
  a_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == ST_OK && length != '0)
    else $error("non-final word with bad status");

  // while a read-out is still running, no new input word is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |-> in_stall)
    else $error("input taken during read-out");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);

/* tb/tb_positional_list_engine.sv */
`timescale 1ns / 1ps
// tb_positional_list_engine: self-checking bench for the list engine, with a mirror of the list
// that predicts every result word, random idling on both sides and a no-progress watchdog
// depends on ple_pkg and positional_list_engine
module tb_positional_list_engine;
  import ple_pkg::*;

  // opcode seven has no operation behind it
  localparam logic [2:0] OP_NOP = 3'd7;
  localparam int NUM_RANDOM = 180;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD = 150;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } reply_t;

  // mirror of the list contents; queues the result words each accepted word must produce
  class list_mirror;
    logic signed [DATA_W-1:0] cells[CAPACITY];
    int count;
    int words_taken;
    int errors;
    reply_t replies[$];

    function void push_reply(logic signed [DATA_W-1:0] v, logic [1:0] s, logic l);
      reply_t r;
      r.value = v;
      r.status = s;
      r.length = count[LEN_W-1:0];
      r.last = l;
      replies.insert(replies.size(), r);
    endfunction

    // new value becomes element slot+1; past the end appends
    function logic [1:0] add_at(int slot, logic signed [DATA_W-1:0] v);
      if (count >= CAPACITY) return ST_FULL;
      if (slot > count) slot = count;
      for (int i = count; i > slot; i--) cells[i] = cells[i-1];
      cells[slot] = v;
      count++;
      return ST_OK;
    endfunction

    // drop element slot+1; past the end drops the last one
    function logic [1:0] drop_at(int slot);
      if (count == 0) return ST_EMPTY;
      if (slot >= count || slot < 0) slot = count - 1;
      for (int i = slot; i < count - 1; i++) cells[i] = cells[i+1];
      count--;
      return ST_OK;
    endfunction

    // note an accepted input word
    function void take_word(logic [2:0] op, logic [POS_W-1:0] pos,
                            logic signed [DATA_W-1:0] v);
      logic [1:0] st;
      int at;
      st = ST_OK;
      at = (pos == 0) ? count : int'(pos) - 1;
      words_taken++;
      case (op)
        OP_APPEND:    st = add_at(count, v);
        OP_PREPEND:   st = add_at(0, v);
        OP_INSERT:    st = add_at(at, v);
        OP_REM_LAST:  st = drop_at(count - 1);
        OP_REM_FIRST: st = drop_at(0);
        OP_REM_POS:   st = drop_at(at);
        OP_READ_ALL: begin
          if (count == 0) push_reply('0, ST_EMPTY, 1'b1);
          else for (int i = 0; i < count; i++) push_reply(cells[i], ST_OK, i == count - 1);
          return;
        end
        default: ;
      endcase
      push_reply('0, st, 1'b1);
    endfunction

    // compare an accepted result word with the oldest expectation
    function void check_word(logic signed [DATA_W-1:0] v, logic [1:0] s,
                             logic [LEN_W-1:0] l, logic la);
      reply_t e;
      if (replies.size() == 0) begin
        $error("result word with nothing expected: value_out %0d status %0d", v, s);
        errors++;
        return;
      end
      e = replies[0];
      replies.delete(0);
      if (v !== e.value) begin
        $error("value_out: expected %0d, got %0d", e.value, v);
        errors++;
      end
      if (s !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, s);
        errors++;
      end
      if (l !== e.length) begin
        $error("length: expected %0d, got %0d", e.length, l);
        errors++;
      end
      if (la !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, la);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               opcode = 3'd0;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] value_out;
  logic [1:0]               status;
  logic [LEN_W-1:0]         length;
  logic                     last;

  list_mirror mirror = new();
  bit settle = 1'b0;
  bit tx_calm = 1'b0;
  int quiet_cycles = 0;

  positional_list_engine uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .position  (position),
    .value_in  (value_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_out (value_out),
    .status    (status),
    .length    (length),
    .last      (last)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // check results before noting inputs taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) mirror.check_word(value_out, status, length, last);
      if (in_valid && !in_stall) mirror.take_word(opcode, position, value_in);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, calm stretches and one long hold-off
  initial begin : rx_side
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && mirror.words_taken >= 60) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!settle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // offer one word, with an optional gap before it, and wait for it to be taken
  task automatic send_word(input logic [2:0] op, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val);
    int gap;
    gap = 0;
    if (!settle && !tx_calm && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    position <= pos;
    value_in <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 63));
    return POS_W'($urandom_range(0, mirror.count + 1));
  endfunction

  // weighted toward adding while growing and toward removing while shrinking
  function automatic logic [2:0] pick_op(bit grow);
    logic [2:0] add_ops[3];
    logic [2:0] rem_ops[3];
    int r;
    add_ops = '{OP_APPEND, OP_PREPEND, OP_INSERT};
    rem_ops = '{OP_REM_LAST, OP_REM_FIRST, OP_REM_POS};
    r = $urandom_range(0, 99);
    if (r < 3) return OP_NOP;
    if (r < 13) return OP_READ_ALL;
    if ((r < 80) == grow) return add_ops[$urandom_range(0, 2)];
    return rem_ops[$urandom_range(0, 2)];
  endfunction

  // stimulus
  initial begin : tx_side
    bit grow;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list cases
    send_word(OP_READ_ALL, 6'd0, 32'sd0);
    send_word(OP_REM_LAST, 6'd0, 32'sd0);
    send_word(OP_REM_FIRST, 6'd0, 32'sd0);
    send_word(OP_REM_POS, 6'd5, 32'sd0);
    send_word(OP_NOP, 6'd63, 32'sd0);
    // field extremes and insert positions: zero, past the end, front, middle, count+1
    send_word(OP_APPEND, 6'd63, 32'sh7fffffff);
    send_word(OP_PREPEND, 6'd0, 32'sh80000000);
    send_word(OP_INSERT, 6'd0, -32'sd1);
    send_word(OP_INSERT, 6'd63, 32'sd0);
    send_word(OP_INSERT, 6'd1, 32'sd1);
    send_word(OP_INSERT, 6'd2, 32'sh55555555);
    send_word(OP_INSERT, 6'd7, 32'shaaaaaaaa);
    send_word(OP_READ_ALL, 6'd0, 32'sd0);
    // remove positions: zero, past the count, front, middle
    send_word(OP_REM_POS, 6'd0, 32'sd0);
    send_word(OP_REM_POS, 6'd63, 32'sd0);
    send_word(OP_REM_POS, 6'd1, 32'sd0);
    send_word(OP_REM_POS, 6'd2, 32'sd0);
    send_word(OP_REM_FIRST, 6'd0, 32'sd0);
    send_word(OP_NOP, 6'd0, 32'sd0);
    send_word(OP_READ_ALL, 6'd0, 32'sd0);
    send_word(OP_REM_LAST, 6'd0, 32'sd0);
    send_word(OP_READ_ALL, 6'd0, 32'sd0);

    // random part: fill to full and past it, drain to empty and past it, repeat
    grow = 1'b1;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 16 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      if (i == NUM_RANDOM - 30) settle = 1'b1;
      if (i == NUM_RANDOM / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.replies.size() != 0) @(posedge clk);
      end
      if (mirror.count >= CAPACITY && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if (mirror.count == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
      send_word(pick_op(grow), pick_position(), pick_value());
    end
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    @(posedge clk);
    while (mirror.replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mirror.errors == 0 && mirror.replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* positional_list_engine.f */
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine.sv
design/ple_checker.sv
tb/tb_positional_list_engine.sv
